>>> hdl/lsp_pkg.sv
package lsp_pkg;

  // Default system size and fixed-point format.
  localparam int DIM_DEF       = 6;
  localparam int FRAC_BITS_DEF = 16;

  // Width of one matrix or solution value.
  localparam int VAL_W = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // A saturated value together with its overflow flag.
  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] val;
  } sat_t;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD = 1'b0;

endpackage

>>> hdl/linear_solve_partial_pivot.sv
// Solves A x = b by Gaussian elimination with partial pivoting and back substitution.
// After the last input item the block copies the loaded matrix, then works through the products
// and quotients, these on one shared serial divider plus its operand reads; Q16.16 by default.
// Results then leave at one item per cycle while m_tready is high, and load items are taken
// one per cycle while idle.
// Reset (rst, synchronous) clears control state, the solution values and sets the threshold to 1.
module linear_solve_partial_pivot
  import lsp_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IDX_W    = $clog2(DIM + 1),
  localparam int IN_W     = ((2 * IDX_W + VAL_W) + 7) / 8 * 8,
  localparam int OUT_W    = ((IDX_W + VAL_W + 2) + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Load channel.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // row_index, column_index, entry_value, zero pad
  input  logic             s_tlast,   // last_entry
  // Result channel.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // solution_index, solution_value, status, zero pad
  output logic             m_tlast,   // last_result
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int COLS   = DIM + 1;
  localparam int DEPTH  = DIM * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SI_W   = $clog2(DIM);
  localparam int NUM_W  = VAL_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_COPY_RD, S_COPY_WR,
    S_PIV_RD, S_PIV_CMP, S_PIV_CHK,
    S_SW_RD1, S_SW_RD2, S_SW_WR1, S_SW_WR2,
    S_EL_RDA, S_EL_RDP, S_EL_DST, S_EL_DIV,
    S_EL_RD1, S_EL_RD2, S_EL_MUL, S_EL_WR,
    S_BS_RDB, S_BS_B, S_BS_RDM, S_BS_MUL, S_BS_SAT, S_BS_SUB,
    S_BS_RDD, S_BS_CHK, S_BS_DIV, S_OUT
  } state_t;

  state_t state;

  // Fixed-point helpers.
  function automatic sat_t from_mag(input logic [63:0] m, input logic neg);
    sat_t s;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s = '{ovf: 1'b1, val: 32'h8000_0000};
      end else begin
        s = '{ovf: 1'b0, val: (~m[VAL_W-1:0]) + 32'd1};
      end
    end else if (m > 64'h7FFF_FFFF) begin
      s = '{ovf: 1'b1, val: 32'h7FFF_FFFF};
    end else begin
      s = '{ovf: 1'b0, val: m[VAL_W-1:0]};
    end
    return s;
  endfunction

  function automatic sat_t mul_sat(input logic signed [63:0] p);
    logic [63:0] mag;
    mag = p[63] ? (~p) + 64'd1 : p;
    return from_mag(mag >> FRAC_BITS, p[63]);
  endfunction

  function automatic sat_t sub_sat(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    logic [VAL_W:0] d;
    sat_t s;
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (d[VAL_W] != d[VAL_W-1]) begin
      s = '{ovf: 1'b1, val: d[VAL_W] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      s = '{ovf: 1'b0, val: d[VAL_W-1:0]};
    end
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v) + 32'd1 : v;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * COLS + int'(c));
  endfunction

  // Configuration register.
  logic [30:0] thr;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {1'b0, thr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 31'd1;
    end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
      thr <= pwdata[30:0];
    end
  end

  // Input field unpacking.
  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;
  logic             in_acc;

  assign in_row = s_tdata[IDX_W-1:0];
  assign in_col = s_tdata[2*IDX_W-1:IDX_W];
  assign in_val = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
  assign s_tready = (state == S_IDLE);
  assign in_acc = s_tvalid && s_tready;

  // Sequencer registers.
  logic [IDX_W-1:0]  r, c, pc, best, k;
  logic [ADDR_W-1:0] cnt;
  logic [VAL_W-1:0]  best_mag;
  logic [VAL_W-1:0]  ta, tb, acc, factor;
  logic signed [63:0] prod;
  sat_t              mres;
  logic              ovf;
  logic              singular;
  status_t           out_status;
  logic [VAL_W-1:0]  sol [DIM];

  // Loaded matrix: written by the load channel, read by the copy sweep.
  logic [VAL_W-1:0] store [DEPTH];
  logic [VAL_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (in_acc && in_row < IDX_W'(DIM) && in_col <= IDX_W'(DIM)) begin
      store[addr_of(in_row, in_col)] <= in_val;
    end
    sq <= store[cnt];
  end

  // Working matrix: one read and one write port.
  logic [VAL_W-1:0]  work [DEPTH];
  logic [VAL_W-1:0]  wq;
  logic [ADDR_W-1:0] w_raddr, w_waddr;
  logic [VAL_W-1:0]  w_wdata;
  logic              w_we;
  sat_t              sub_res;
  sat_t              mul_res;

  assign sub_res = sub_sat((state == S_BS_SUB) ? acc : tb, mres.val);
  assign mul_res = mul_sat(prod);

  always_comb begin
    w_raddr = addr_of(r, c);
    w_waddr = addr_of(r, c);
    w_wdata = sub_res.val;
    w_we    = 1'b0;
    unique case (state)
      S_PIV_RD: w_raddr = addr_of(r, pc);
      S_SW_RD1: w_raddr = addr_of(pc, c);
      S_SW_RD2: w_raddr = addr_of(best, c);
      S_EL_RDA: w_raddr = addr_of(r, pc);
      S_EL_RDP: w_raddr = addr_of(pc, pc);
      S_EL_RD1: w_raddr = addr_of(pc, c);
      S_BS_RDB: w_raddr = addr_of(r, IDX_W'(DIM));
      S_BS_RDD: w_raddr = addr_of(r, r);
      S_COPY_WR: begin
        w_waddr = cnt;
        w_wdata = sq;
        w_we    = 1'b1;
      end
      S_SW_WR1: begin
        w_waddr = addr_of(pc, c);
        w_wdata = wq;
        w_we    = 1'b1;
      end
      S_SW_WR2: begin
        w_waddr = addr_of(best, c);
        w_wdata = ta;
        w_we    = 1'b1;
      end
      S_EL_WR: w_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      work[w_waddr] <= w_wdata;
    end
    wq <= work[w_raddr];
  end

  // Pivot test on the value just read.
  logic [VAL_W-1:0] rd_mag;
  logic             rd_bad;
  logic             best_bad;

  assign rd_mag   = mag32(wq);
  assign rd_bad   = (rd_mag == '0) || (rd_mag < {1'b0, thr});
  assign best_bad = (best_mag == '0) || (best_mag < {1'b0, thr});

  // Shared serial divider: (|n| << FRAC_BITS) / |d|, one quotient bit per cycle.
  logic              dv_start;
  logic [VAL_W-1:0]  dv_n;
  logic              dv_busy, dv_done, dv_neg;
  logic [DCNT_W-1:0] dv_cnt;
  logic [NUM_W-1:0]  dv_num, dv_q;
  logic [VAL_W:0]    dv_rem, dv_rsh;
  logic [VAL_W-1:0]  dv_den;
  sat_t              div_res;

  assign dv_start = (state == S_EL_DST) || (state == S_BS_CHK && !rd_bad);
  assign dv_n     = (state == S_EL_DST) ? ta : acc;
  assign dv_rsh   = {dv_rem[VAL_W-1:0], dv_num[NUM_W-1]};
  assign div_res  = from_mag(64'(dv_q), dv_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt  <= '0;
    end else begin
      dv_done <= 1'b0;
      if (dv_start) begin
        dv_busy <= 1'b1;
        dv_cnt  <= DCNT_W'(NUM_W);
        dv_num  <= NUM_W'(mag32(dv_n)) << FRAC_BITS;
        dv_den  <= mag32(wq);
        dv_neg  <= dv_n[VAL_W-1] ^ wq[VAL_W-1];
        dv_rem  <= '0;
        dv_q    <= '0;
      end else if (dv_busy) begin
        dv_num <= dv_num << 1;
        if (dv_rsh >= {1'b0, dv_den}) begin
          dv_rem <= dv_rsh - {1'b0, dv_den};
          dv_q   <= {dv_q[NUM_W-2:0], 1'b1};
        end else begin
          dv_rem <= dv_rsh;
          dv_q   <= {dv_q[NUM_W-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt - DCNT_W'(1);
        if (dv_cnt == DCNT_W'(1)) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ovf        <= 1'b0;
      singular   <= 1'b0;
      cnt        <= '0;
      k          <= '0;
      for (int i = 0; i < DIM; i++) begin
        sol[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && s_tlast) begin
            ovf      <= 1'b0;
            singular <= 1'b0;
            cnt      <= '0;
            for (int i = 0; i < DIM; i++) begin
              sol[i] <= '0;
            end
            state <= S_COPY_RD;
          end
        end
        // Copy the loaded matrix into the working memory.
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          if (cnt == ADDR_W'(DEPTH - 1)) begin
            pc    <= '0;
            r     <= '0;
            state <= S_PIV_RD;
          end else begin
            cnt   <= cnt + ADDR_W'(1);
            state <= S_COPY_RD;
          end
        end
        // Search the pivot column from the diagonal down; first largest wins.
        S_PIV_RD: state <= S_PIV_CMP;
        S_PIV_CMP: begin
          if (r == pc || rd_mag > best_mag) begin
            best     <= r;
            best_mag <= rd_mag;
          end
          if (r == IDX_W'(DIM - 1)) begin
            state <= S_PIV_CHK;
          end else begin
            r     <= r + IDX_W'(1);
            state <= S_PIV_RD;
          end
        end
        S_PIV_CHK: begin
          if (best_bad) begin
            singular <= 1'b1;
            state    <= S_OUT;
          end else if (best != pc) begin
            c     <= pc;
            state <= S_SW_RD1;
          end else if (pc == IDX_W'(DIM - 1)) begin
            r     <= IDX_W'(DIM - 1);
            state <= S_BS_RDB;
          end else begin
            r     <= pc + IDX_W'(1);
            state <= S_EL_RDA;
          end
        end
        // Swap the pivot row with the diagonal row, one column at a time.
        S_SW_RD1: state <= S_SW_RD2;
        S_SW_RD2: begin
          ta    <= wq;
          state <= S_SW_WR1;
        end
        S_SW_WR1: state <= S_SW_WR2;
        S_SW_WR2: begin
          if (c != IDX_W'(DIM)) begin
            c     <= c + IDX_W'(1);
            state <= S_SW_RD1;
          end else if (pc == IDX_W'(DIM - 1)) begin
            r     <= IDX_W'(DIM - 1);
            state <= S_BS_RDB;
          end else begin
            r     <= pc + IDX_W'(1);
            state <= S_EL_RDA;
          end
        end
        // Row factor: m[r][pc] / m[pc][pc].
        S_EL_RDA: state <= S_EL_RDP;
        S_EL_RDP: begin
          ta    <= wq;
          state <= S_EL_DST;
        end
        S_EL_DST: state <= S_EL_DIV;
        S_EL_DIV: begin
          if (dv_done) begin
            factor <= div_res.val;
            ovf    <= ovf | div_res.ovf;
            c      <= pc + IDX_W'(1);
            state  <= S_EL_RD1;
          end
        end
        // m[r][c] -= factor * m[pc][c].
        S_EL_RD1: state <= S_EL_RD2;
        S_EL_RD2: begin
          prod  <= $signed(factor) * $signed(wq);
          state <= S_EL_MUL;
        end
        S_EL_MUL: begin
          tb    <= wq;
          mres  <= mul_res;
          ovf   <= ovf | mul_res.ovf;
          state <= S_EL_WR;
        end
        S_EL_WR: begin
          ovf <= ovf | sub_res.ovf;
          if (c != IDX_W'(DIM)) begin
            c     <= c + IDX_W'(1);
            state <= S_EL_RD1;
          end else if (r == IDX_W'(DIM - 1)) begin
            pc    <= pc + IDX_W'(1);
            r     <= pc + IDX_W'(1);
            state <= S_PIV_RD;
          end else begin
            r     <= r + IDX_W'(1);
            state <= S_EL_RDA;
          end
        end
        // Back substitution from the last row up.
        S_BS_RDB: state <= S_BS_B;
        S_BS_B: begin
          acc <= wq;
          if (r == IDX_W'(DIM - 1)) begin
            state <= S_BS_RDD;
          end else begin
            c     <= r + IDX_W'(1);
            state <= S_BS_RDM;
          end
        end
        S_BS_RDM: state <= S_BS_MUL;
        S_BS_MUL: begin
          prod  <= $signed(wq) * $signed(sol[c[SI_W-1:0]]);
          state <= S_BS_SAT;
        end
        S_BS_SAT: begin
          mres  <= mul_res;
          ovf   <= ovf | mul_res.ovf;
          state <= S_BS_SUB;
        end
        S_BS_SUB: begin
          acc <= sub_res.val;
          ovf <= ovf | sub_res.ovf;
          if (c == IDX_W'(DIM - 1)) begin
            state <= S_BS_RDD;
          end else begin
            c     <= c + IDX_W'(1);
            state <= S_BS_RDM;
          end
        end
        S_BS_RDD: state <= S_BS_CHK;
        S_BS_CHK: begin
          if (rd_bad) begin
            singular <= 1'b1;
            state    <= S_OUT;
          end else begin
            state <= S_BS_DIV;
          end
        end
        S_BS_DIV: begin
          if (dv_done) begin
            sol[r[SI_W-1:0]] <= div_res.val;
            ovf              <= ovf | div_res.ovf;
            if (r == '0) begin
              state <= S_OUT;
            end else begin
              r     <= r - IDX_W'(1);
              state <= S_BS_RDB;
            end
          end
        end
        // Results leave in index order; the solution values shift down.
        S_OUT: begin
          if (m_tready) begin
            for (int i = 0; i < DIM - 1; i++) begin
              sol[i] <= sol[i+1];
            end
            sol[DIM-1] <= '0;
            if (k == IDX_W'(DIM - 1)) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result channel; the flags are stable for the whole result phase.
  logic [VAL_W-1:0] out_val;

  assign out_status = singular ? ST_SINGULAR : (ovf ? ST_OVERFLOW : ST_OK);
  assign out_val  = (out_status == ST_SINGULAR) ? '0 : sol[0];
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (k == IDX_W'(DIM - 1));
  assign m_tdata  = OUT_W'({out_status, out_val, k});

  // Loading and result delivery never overlap.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("load channel ready while results pending");

  // The divider is never restarted while it is still running.
  assert property (@(posedge clk) disable iff (rst) dv_start |-> !dv_busy)
    else $error("divider started while busy");

  // A singular result carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_SINGULAR) |-> (m_tdata[IDX_W+VAL_W-1:IDX_W] == '0))
    else $error("singular result with nonzero value");

  // After the last result is taken the block returns to loading.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block did not return to loading");

endmodule

>>> verif/lsp_checker.sv
module lsp_checker
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // row_index, column_index, entry_value, zero pad
  input  logic        s_tlast,   // last_entry
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // solution_index, solution_value, status, zero pad
  input  logic        m_tlast,   // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          fails,
  output int          solves,
  output int          singulars,
  output int          overflows
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N    = DIM_DEF;
  localparam int COLS = N + 1;
  localparam int FB   = FRAC_BITS_DEF;

  typedef struct {
    logic [2:0]  index;
    logic [31:0] value;
    status_t     status;
    logic        last;
  } solution_t;

  // Mirror of the block's state.
  int          loaded [N*COLS];
  int          x_vals [N];
  bit          saturated;
  logic [30:0] threshold;
  solution_t   solutions_due [$];

  assign pending = solutions_due.size();

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Applies the sign to a magnitude and saturates to 32 bits.
  function automatic int apply_sign(longint unsigned m, bit neg);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        saturated = 1;
        return 32'h8000_0000;
      end
      return int'(longint'(0) - longint'(m));
    end
    if (m > 64'h7FFF_FFFF) begin
      saturated = 1;
      return 32'h7FFF_FFFF;
    end
    return int'(m);
  endfunction

  function automatic int q_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return apply_sign(magnitude(p) >> FB, p < 0);
  endfunction

  function automatic int q_div(int n, int d);
    longint unsigned num, den;
    num = magnitude(n) << FB;
    den = magnitude(d);
    if (den == 0) return 0;
    return apply_sign(num / den, (n < 0) != (d < 0));
  endfunction

  function automatic int q_sub(int a, int b);
    longint v;
    v = longint'(a) - longint'(b);
    if (v > 64'sh7FFF_FFFF) begin
      saturated = 1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      saturated = 1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic bit pivot_weak(int v);
    longint unsigned m;
    m = magnitude(v);
    return m == 0 || m < longint'(threshold);
  endfunction

  // Forward elimination with row exchange, then back substitution.
  // Returns 1 when a pivot is too small.
  function automatic bit eliminate();
    int w [N][COLS];
    int best, t, factor, acc;
    longint unsigned best_mag, cand;
    for (int r = 0; r < N; r++)
      for (int c = 0; c < COLS; c++)
        w[r][c] = loaded[r*COLS + c];
    for (int p = 0; p < N; p++) begin
      best = p;
      best_mag = magnitude(w[p][p]);
      for (int r = p + 1; r < N; r++) begin
        cand = magnitude(w[r][p]);
        if (cand > best_mag) begin
          best_mag = cand;
          best = r;
        end
      end
      if (pivot_weak(w[best][p])) return 1;
      if (best != p)
        for (int c = p; c < COLS; c++) begin
          t = w[p][c];
          w[p][c] = w[best][c];
          w[best][c] = t;
        end
      for (int r = p + 1; r < N; r++) begin
        factor = q_div(w[r][p], w[p][p]);
        w[r][p] = 0;
        for (int c = p + 1; c < COLS; c++)
          w[r][c] = q_sub(w[r][c], q_mul(factor, w[p][c]));
      end
    end
    for (int r = N - 1; r >= 0; r--) begin
      acc = w[r][N];
      for (int c = r + 1; c < N; c++)
        acc = q_sub(acc, q_mul(w[r][c], x_vals[c]));
      if (pivot_weak(w[r][r])) return 1;
      x_vals[r] = q_div(acc, w[r][r]);
    end
    return 0;
  endfunction

  // Takes one load item and queues the solution items it causes.
  task automatic take_entry(logic [39:0] d, logic last);
    logic [2:0] row, col;
    bit         sing;
    status_t    st;
    solution_t  s;
    row = d[2:0];
    col = d[5:3];
    if (row < N && col <= N) loaded[row*COLS + col] = int'(d[37:6]);
    if (!last) return;
    saturated = 0;
    foreach (x_vals[k]) x_vals[k] = 0;
    sing = eliminate();
    solves++;
    if (sing) begin
      foreach (x_vals[k]) x_vals[k] = 0;
      st = ST_SINGULAR;
      singulars++;
    end else if (saturated) begin
      st = ST_OVERFLOW;
      overflows++;
    end else begin
      st = ST_OK;
    end
    for (int k = 0; k < N; k++) begin
      s.index  = 3'(k);
      s.value  = x_vals[k];
      s.status = st;
      s.last   = (k == N - 1);
      solutions_due.push_back(s);
    end
  endtask

  // Compares one solution item with the oldest one due.
  task automatic check_solution(logic [39:0] d, logic last);
    solution_t s;
    if (solutions_due.size() == 0) begin
      $error("unexpected solution item: tdata %h", d);
      fails++;
      return;
    end
    s = solutions_due.pop_front();
    if (d[2:0] !== s.index) begin
      $error("solution_index expected %0d actual %0d", s.index, d[2:0]);
      fails++;
    end
    if (d[34:3] !== s.value) begin
      $error("solution_value expected %h actual %h", s.value, d[34:3]);
      fails++;
    end
    if (d[36:35] !== s.status) begin
      $error("status expected %0d actual %0d", s.status, d[36:35]);
      fails++;
    end
    if (last !== s.last) begin
      $error("last_result expected %0b actual %0b", s.last, last);
      fails++;
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      foreach (loaded[k]) loaded[k] = 0;
      foreach (x_vals[k]) x_vals[k] = 0;
      saturated = 0;
      threshold = 31'd1;
      solutions_due.delete();
      fails = 0;
      solves = 0;
      singulars = 0;
      overflows = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_THRESHOLD, 2'b00})
        threshold = pwdata[30:0];
      if (s_tvalid && s_tready) take_entry(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_solution(m_tdata, m_tlast);
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  import lsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 600000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // row_index, column_index, entry_value, zero pad
  logic        s_tlast = 0;    // last_entry
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;        // solution_index, solution_value, status, zero pad
  logic        m_tlast;        // last_result
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending, fails, solves, singulars, overflows;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  int cycles = 0;
  int entries_sent = 0;
  logic hold_go = 0;

  linear_solve_partial_pivot dut (.*);

  lsp_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_go) begin
      hold_cnt <= 3000;
      m_tready <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one load item, after random idle cycles, and waits for acceptance.
  task automatic send_entry(logic [2:0] row, logic [2:0] col, logic [31:0] v, logic last);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1;
    s_tdata  <= {2'b00, v, col, row};
    s_tlast  <= last;
    // Ready is judged as it stands at the edge itself.
    @(posedge clk iff s_tready);
    entries_sent++;
  endtask

  task automatic write_threshold(logic [31:0] v);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // Waits until every solution has arrived and the block is idle.
  task automatic drain();
    s_tvalid <= 0;
    s_tlast  <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] signed_rand(int unsigned lo, int unsigned hi);
    logic [31:0] m;
    m = $urandom_range(hi, lo);
    return $urandom_range(1) ? -m : m;
  endfunction

  // Loads a system with a large random diagonal and smaller random other entries and solves it.
  task automatic load_system();
    logic [31:0] v;
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 7; c++) begin
        if (c == r) v = signed_rand(32'h4_0000, 32'h10_0000);
        else if (c == 6) v = signed_rand(0, 32'h8_0000);
        else v = signed_rand(0, 32'h1_0000);
        send_entry(3'(r), 3'(c), v, r == 5 && c == 6);
      end
  endtask

  // Sparse updates: mostly in range, sometimes full-scale values.
  task automatic random_entries(int count);
    logic [2:0]  row, col;
    logic [31:0] v;
    for (int k = 0; k < count; k++) begin
      row = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      col = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
      v = ($urandom_range(9) < 7) ? signed_rand(0, 32'h2_0000) : $urandom;
      send_entry(row, col, v, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int          thresholds [4];
    int          idles [4];
    int          stalls [4];
    thresholds = '{0, 32'h7FFF_FFFF, 32'h0000_8000, 1};
    idles      = '{0, 85, 0, 28};
    stalls     = '{0, 0, 85, 28};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a full load, saturating entries, a zero pivot column,
    // out-of-range writes that still start a solve, and field extremes.
    load_system();
    send_entry(3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0);
    send_entry(3'd1, 3'd0, 32'h8000_0000, 1'b0);
    send_entry(3'd5, 3'd6, 32'h7FFF_FFFF, 1'b1);
    for (int r = 0; r < 6; r++) send_entry(3'(r), 3'd0, 32'h0, r == 5);
    send_entry(3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1);
    send_entry(3'd6, 3'd2, 32'h1234_5678, 1'b0);
    send_entry(3'd2, 3'd7, 32'h0001_0000, 1'b0);
    for (int r = 0; r < 6; r++) send_entry(3'(r), 3'd0, 32'h0004_0000, r == 5);
    send_entry(3'd5, 3'd5, 32'h0000_0001, 1'b1);
    drain();

    // Phases with different thresholds and idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thresholds[ph]);
      idle_pct  <= idles[ph];
      stall_pct <= stalls[ph];
      if (ph == 2) begin
        hold_go <= 1;
        @(posedge clk);
        hold_go <= 0;
      end
      load_system();
      random_entries(20);
      drain();
    end

    repeat (2000) @(posedge clk);
    $display("Sent %0d load items through four threshold settings and idling patterns.",
             entries_sent);
    $display("Solves %0d: %0d singular, %0d saturated.", solves, singulars, overflows);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/lsp_pkg.sv
hdl/linear_solve_partial_pivot.sv
verif/lsp_checker.sv
verif/tb.sv
